// ----- hdl/bda_pkg.sv -----
// shared constants and helpers for the binary to decimal ascii converter
package bda_pkg;

	localparam int VALUE_WIDTH = 64;
	// decimal digits needed for the largest unsigned value of VALUE_WIDTH bits
	localparam int MAX_CHARS = 20;
	localparam int BCD_WIDTH = 4 * MAX_CHARS;
	localparam int STEP_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
	localparam int DIGIT_IDX_WIDTH = $clog2(MAX_CHARS);

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef logic [VALUE_WIDTH-1:0] mag_t;
	typedef logic [BCD_WIDTH-1:0] bcd_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		digit_char = CH_ZERO | {4'b0000, d};
	endfunction

endpackage

// ----- hdl/bda_dabble.sv -----
// iterative shift-and-add-3 unit: one binary bit moves into the bcd register per cycle
module bda_dabble (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bda_pkg::mag_t      mag,
	output logic               done,
	output bda_pkg::bcd_t      bcd
);

	bda_pkg::mag_t                            bin_q;
	bda_pkg::bcd_t                            bcd_q;
	logic [bda_pkg::STEP_CNT_WIDTH-1:0]       cnt_q;
	logic                                     running_q;
	logic                                     done_q;
	bda_pkg::bcd_t                            adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < bda_pkg::MAX_CHARS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + bda_pkg::STEP_CNT_WIDTH'(1);
				if (cnt_q == bda_pkg::STEP_CNT_WIDTH'(bda_pkg::VALUE_WIDTH - 1)) begin
					running_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (running_q) begin
			bin_q <= {bin_q[bda_pkg::VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {adj[bda_pkg::BCD_WIDTH-2:0], bin_q[bda_pkg::VALUE_WIDTH-1]};
		end
	end

	assign done = done_q;
	assign bcd = bcd_q;

endmodule

// ----- hdl/binary_to_decimal_ascii.sv -----
// top level: decimal ascii converter with input register, sequencer and output register
//
// Input channel item_valid / item_stall carries value and is_signed; an item is
// taken on a clock edge with item_valid high and item_stall low. value is read as
// unsigned, or as two's complement when is_signed is 1.
// Output channel char_valid / char_stall carries one ascii character per transfer
// (char_code), most significant first, with last high on the final character.
// A negative number starts with '-', leading zeros are dropped, zero gives '0'.
// After an item is taken the shift-and-add-3 unit shifts in the magnitude one
// bit per cycle; the sequencer then skips one leading zero digit per cycle (up
// to 19) and emits one character per cycle while the receiver does not stall.
// item_stall is high from accept until the last character is loaded into the
// output register. On a receiver stall the output register holds its character
// and the next waits, while leading zeros are still skipped. Reset (arst_n low,
// asynchronous) empties the output register and returns the sequencer to idle.
module binary_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [63:0] value,
	input  logic        is_signed,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  char_code,
	output logic        last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_EMIT
	} state_t;

	state_t                                   state_q;
	logic                                     neg_q;
	logic                                     started_q;
	logic [bda_pkg::DIGIT_IDX_WIDTH-1:0]      idx_q;
	bda_pkg::bcd_t                            digits_q;
	logic                                     char_valid_q;
	logic [7:0]                               char_code_q;
	logic                                     last_q;

	logic                                     accept;
	logic                                     in_neg;
	bda_pkg::mag_t                            in_val;
	bda_pkg::mag_t                            in_mag;
	logic                                     conv_done;
	bda_pkg::bcd_t                            conv_bcd;
	logic                                     slot_free;
	logic [3:0]                               top_digit;
	logic                                     skip_zero;

	assign item_stall = (state_q != S_IDLE);
	assign accept = item_valid && (state_q == S_IDLE);

	always_comb begin
		in_val = value[bda_pkg::VALUE_WIDTH-1:0];
		in_neg = is_signed && in_val[bda_pkg::VALUE_WIDTH-1];
		// most negative value wraps to 2^(w-1), exact as unsigned
		in_mag = in_neg ? (~in_val + bda_pkg::mag_t'(1)) : in_val;
	end

	bda_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (in_mag),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	assign slot_free = !char_valid_q || !char_stall;
	assign top_digit = digits_q[bda_pkg::BCD_WIDTH-1 -: 4];
	assign skip_zero = !started_q && (top_digit == 4'd0) && (idx_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			char_valid_q <= 1'b0;
			neg_q <= 1'b0;
			started_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (char_valid_q && !char_stall) begin
				char_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						neg_q <= in_neg;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (conv_done) begin
						started_q <= 1'b0;
						idx_q <= bda_pkg::DIGIT_IDX_WIDTH'(bda_pkg::MAX_CHARS - 1);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (neg_q) begin
						if (slot_free) begin
							char_valid_q <= 1'b1;
							neg_q <= 1'b0;
						end
					end else if (skip_zero) begin
						idx_q <= idx_q - bda_pkg::DIGIT_IDX_WIDTH'(1);
					end else if (slot_free) begin
						char_valid_q <= 1'b1;
						started_q <= 1'b1;
						idx_q <= idx_q - bda_pkg::DIGIT_IDX_WIDTH'(1);
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// digit shift register and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_CONV && conv_done) begin
			digits_q <= conv_bcd;
		end else if (state_q == S_EMIT && !neg_q && (skip_zero || slot_free)) begin
			digits_q <= {digits_q[bda_pkg::BCD_WIDTH-5:0], 4'b0000};
		end
		if (state_q == S_EMIT && slot_free) begin
			if (neg_q) begin
				char_code_q <= bda_pkg::CH_MINUS;
				last_q <= 1'b0;
			end else if (!skip_zero) begin
				char_code_q <= bda_pkg::digit_char(top_digit);
				last_q <= (idx_q == '0);
			end
		end
	end

	assign char_valid = char_valid_q;
	assign char_code = char_code_q;
	assign last = last_q;

endmodule
